// ===== rtl/swoi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square window obstacle inflation: shared definitions
// Register map, field widths, reset values and the stage-one control word.
// ----------------------------------------------------------------------------
package swoi_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_MARGIN_DEF = 8;
  localparam int MAX_HEIGHT     = 4096;

  localparam int PIX_BITS    = 8;
  localparam int IMG_W_BITS  = 11;
  localparam int IMG_H_BITS  = 13;
  localparam int MARGIN_BITS = 4;
  localparam int CFG_IW      = 2;
  localparam int CFG_DW      = 13;

  localparam int RESET_WIDTH     = 640;
  localparam int RESET_HEIGHT    = 480;
  localparam int RESET_MARGIN    = 0;
  localparam int RESET_THRESHOLD = 125;

  typedef enum logic [CFG_IW-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_MARGIN         = 2'd2,
    REG_DARK_THRESHOLD = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Control word of the item in the read-modify-write stage.
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
    logic dark;
    logic row0;
    logic bypass;
  } s1_ctl_t;

  // Bits of a raster position, including the drain tail of a frame.
  function automatic int pos_bits(int max_w, int max_m);
    return $clog2(max_w * MAX_HEIGHT + (max_m + 1) * max_w + max_m);
  endfunction

  // Address bits of the pixel delay line; its depth exceeds the largest delay.
  function automatic int store_bits(int max_w, int max_m);
    return $clog2(max_m * max_w + max_m + 1);
  endfunction

endpackage

// ===== rtl/swoi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square window obstacle inflation: stream channels
// Pixel input channel and inflated pixel output channel, valid/ready.
// ----------------------------------------------------------------------------
interface swoi_in_if;
  import swoi_pkg::*;

  logic                valid;
  logic                ready;
  op_t                 op;
  logic [PIX_BITS-1:0] pixel_in;

  modport source (output valid, op, pixel_in, input ready);
  modport sink   (input valid, op, pixel_in, output ready);
endinterface

interface swoi_out_if;
  import swoi_pkg::*;

  logic                valid;
  logic                ready;
  logic [PIX_BITS-1:0] pixel_out;
  logic                last;

  modport source (output valid, pixel_out, last, input ready);
  modport sink   (input valid, pixel_out, last, output ready);
endinterface

// ===== rtl/square_window_obstacle_inflation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square window obstacle inflation
// Raster-order occupancy map filter: a pixel becomes 0 when any pixel within
// the square window of half width margin is darker than the threshold.
// ----------------------------------------------------------------------------
//   channel   direction  handshake       word
//   in_ch     sink       valid / ready   op, pixel_in
//   out_ch    source     valid / ready   pixel_out, last
//   cfg_*     sink       cfg_we only     cfg_index, cfg_wdata
//
// One word per clock is accepted while ready is high; a word passes the column
// read-modify-write stage and then sits in the output register.
// Output lags input by margin rows plus margin pixels; drain words push the
// tail out. The per-column memory needs no clearing pass: row 0 of every frame
// rewrites each column before it is read. Ready stays low after reset, and
// a configuration write holds it low from its own cycle until the derived
// frame size and delay are registered. A stalled output register stops the
// whole pipeline and ready drops in the same cycle.
// ----------------------------------------------------------------------------
module square_window_obstacle_inflation #(
  parameter int MAX_WIDTH  = swoi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_MARGIN = swoi_pkg::MAX_MARGIN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  swoi_in_if.sink                      in_ch,
  swoi_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [swoi_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [swoi_pkg::CFG_DW-1:0]  cfg_wdata
);
  import swoi_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int MW  = $clog2(MAX_MARGIN + 1);
  localparam int QW  = pos_bits(MAX_WIDTH, MAX_MARGIN);
  localparam int AW  = store_bits(MAX_WIDTH, MAX_MARGIN);
  localparam int RDW = $clog2(2 * MAX_MARGIN + 2);
  localparam int WL  = 2 * MAX_MARGIN + 1;
  localparam int STORE_DEPTH = 1 << AW;

  logic [WW-1:0]       w;
  logic [MW-1:0]       m;
  logic [QW-1:0]       total;
  logic [QW-1:0]       delay;
  logic [QW-1:0]       end_pos;
  logic [PIX_BITS-1:0] thr;
  logic                blk;

  logic                en;
  logic                go;
  logic [CW-1:0]       s0_col;
  logic                store_we;
  logic [AW-1:0]       store_waddr;
  logic [AW-1:0]       store_raddr;
  logic [PIX_BITS-1:0] store_rdata;
  s1_ctl_t             ctl;
  logic [CW-1:0]       s1_col;
  logic [PIX_BITS-1:0] s1_pix;
  logic [WL-1:0]       s1_mask;

  logic                rsd_we;
  logic [CW-1:0]       rsd_waddr;
  logic [RDW-1:0]      rsd_wdata;
  logic [RDW-1:0]      rsd_rdata;

  swoi_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_MARGIN (MAX_MARGIN)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .w_o       (w),
    .m_o       (m),
    .total_o   (total),
    .delay_o   (delay),
    .end_o     (end_pos),
    .thr_o     (thr),
    .blk_o     (blk)
  );

  swoi_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_MARGIN (MAX_MARGIN)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_op       (in_ch.op),
    .in_pix      (in_ch.pixel_in),
    .in_ready    (in_ch.ready),
    .en          (en),
    .blk         (blk),
    .w           (w),
    .m           (m),
    .total       (total),
    .delay       (delay),
    .end_pos     (end_pos),
    .thr         (thr),
    .go_o        (go),
    .col_o       (s0_col),
    .store_we    (store_we),
    .store_waddr (store_waddr),
    .store_raddr (store_raddr),
    .ctl_o       (ctl),
    .s1_col_o    (s1_col),
    .s1_pix_o    (s1_pix),
    .s1_mask_o   (s1_mask)
  );

  // Pixel delay line, addressed by raster position modulo its depth.
  swoi_ram #(
    .WIDTH (PIX_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (in_ch.pixel_in),
    .re    (go),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // Rows since the last dark pixel, one entry per column.
  swoi_ram #(
    .WIDTH (RDW),
    .DEPTH (MAX_WIDTH)
  ) u_rsd (
    .clk   (clk),
    .we    (rsd_we),
    .waddr (rsd_waddr),
    .wdata (rsd_wdata),
    .re    (go),
    .raddr (s0_col),
    .rdata (rsd_rdata)
  );

  swoi_win #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_MARGIN (MAX_MARGIN)
  ) u_win (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .s1_col      (s1_col),
    .s1_pix      (s1_pix),
    .s1_mask     (s1_mask),
    .m           (m),
    .go          (go),
    .s0_col      (s0_col),
    .rsd_rdata   (rsd_rdata),
    .store_rdata (store_rdata),
    .rsd_we      (rsd_we),
    .rsd_waddr   (rsd_waddr),
    .rsd_wdata   (rsd_wdata),
    .en          (en),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_pixel   (out_ch.pixel_out),
    .out_last    (out_ch.last)
  );

`ifndef SYNTHESIS
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready)
    else $error("input word taken right after a configuration write");

  a_last_is_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.valid && ctl.last) |-> ctl.emit)
    else $error("last flag on a word that produces no pixel");

  a_stall_reaches_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while the output register is stalled");
`endif

endmodule

// ===== rtl/swoi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module swoi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/swoi_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square window obstacle inflation: configuration
// Register file, range clamping and the derived frame size and delay.
// ----------------------------------------------------------------------------
module swoi_cfg #(
  parameter int MAX_WIDTH  = swoi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_MARGIN = swoi_pkg::MAX_MARGIN_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   cfg_we,
  input  logic [swoi_pkg::CFG_IW-1:0]                            cfg_index,
  input  logic [swoi_pkg::CFG_DW-1:0]                            cfg_wdata,
  output logic [$clog2(MAX_WIDTH+1)-1:0]                         w_o,
  output logic [$clog2(MAX_MARGIN+1)-1:0]                        m_o,
  output logic [swoi_pkg::pos_bits(MAX_WIDTH, MAX_MARGIN)-1:0]   total_o,
  output logic [swoi_pkg::pos_bits(MAX_WIDTH, MAX_MARGIN)-1:0]   delay_o,
  output logic [swoi_pkg::pos_bits(MAX_WIDTH, MAX_MARGIN)-1:0]   end_o,
  output logic [swoi_pkg::PIX_BITS-1:0]                          thr_o,
  output logic                                                   blk_o
);
  import swoi_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int MW = $clog2(MAX_MARGIN + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int QW = pos_bits(MAX_WIDTH, MAX_MARGIN);

  logic [IMG_W_BITS-1:0]  width_r;
  logic [IMG_H_BITS-1:0]  height_r;
  logic [MARGIN_BITS-1:0] margin_r;
  logic [PIX_BITS-1:0]    thr_r;
  logic [1:0]             blk_r;

  logic [WW-1:0] w_c;
  logic [HW-1:0] h_c;
  logic [MW-1:0] m_c;

  logic [WW-1:0] w_r;
  logic [MW-1:0] m_r;
  logic [QW-1:0] total_r;
  logic [QW-1:0] delay_r;
  logic [QW-1:0] end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMG_W_BITS'(RESET_WIDTH);
      height_r <= IMG_H_BITS'(RESET_HEIGHT);
      margin_r <= MARGIN_BITS'(RESET_MARGIN);
      thr_r    <= PIX_BITS'(RESET_THRESHOLD);
      blk_r    <= 2'b11;
    end else begin
      blk_r <= {blk_r[0], cfg_we};
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:    width_r  <= cfg_wdata[IMG_W_BITS-1:0];
          REG_IMAGE_HEIGHT:   height_r <= cfg_wdata[IMG_H_BITS-1:0];
          REG_MARGIN:         margin_r <= cfg_wdata[MARGIN_BITS-1:0];
          REG_DARK_THRESHOLD: thr_r    <= cfg_wdata[PIX_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_c = WW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(width_r);
    end

    if (height_r == '0) begin
      h_c = HW'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_c = HW'(MAX_HEIGHT);
    end else begin
      h_c = HW'(height_r);
    end

    if (int'(margin_r) > MAX_MARGIN) begin
      m_c = MW'(MAX_MARGIN);
    end else begin
      m_c = MW'(margin_r);
    end
  end

  // Two register stages: products first, then the end position from them.
  // The input is held off from a write until both stages hold the new values.
  always_ff @(posedge clk) begin
    w_r     <= w_c;
    m_r     <= m_c;
    total_r <= QW'(w_c) * QW'(h_c);
    delay_r <= QW'(m_c) * QW'(w_c) + QW'(m_c);
    end_r   <= total_r + delay_r - QW'(1);
  end

  assign w_o     = w_r;
  assign m_o     = m_r;
  assign total_o = total_r;
  assign delay_o = delay_r;
  assign end_o   = end_r;
  assign thr_o   = thr_r;
  assign blk_o   = cfg_we | (|blk_r);

endmodule

// ===== rtl/swoi_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square window obstacle inflation: input sequencer
// Tracks raster positions, issues memory accesses and loads stage one.
// ----------------------------------------------------------------------------
module swoi_seq #(
  parameter int MAX_WIDTH  = swoi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_MARGIN = swoi_pkg::MAX_MARGIN_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   in_valid,
  input  swoi_pkg::op_t                                          in_op,
  input  logic [swoi_pkg::PIX_BITS-1:0]                          in_pix,
  output logic                                                   in_ready,
  input  logic                                                   en,
  input  logic                                                   blk,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                         w,
  input  logic [$clog2(MAX_MARGIN+1)-1:0]                        m,
  input  logic [swoi_pkg::pos_bits(MAX_WIDTH, MAX_MARGIN)-1:0]   total,
  input  logic [swoi_pkg::pos_bits(MAX_WIDTH, MAX_MARGIN)-1:0]   delay,
  input  logic [swoi_pkg::pos_bits(MAX_WIDTH, MAX_MARGIN)-1:0]   end_pos,
  input  logic [swoi_pkg::PIX_BITS-1:0]                          thr,
  output logic                                                   go_o,
  output logic [$clog2(MAX_WIDTH)-1:0]                           col_o,
  output logic                                                   store_we,
  output logic [swoi_pkg::store_bits(MAX_WIDTH, MAX_MARGIN)-1:0] store_waddr,
  output logic [swoi_pkg::store_bits(MAX_WIDTH, MAX_MARGIN)-1:0] store_raddr,
  output swoi_pkg::s1_ctl_t                                      ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0]                           s1_col_o,
  output logic [swoi_pkg::PIX_BITS-1:0]                          s1_pix_o,
  output logic [2*MAX_MARGIN:0]                                  s1_mask_o
);
  import swoi_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int MW = $clog2(MAX_MARGIN + 1);
  localparam int QW = pos_bits(MAX_WIDTH, MAX_MARGIN);
  localparam int AW = store_bits(MAX_WIDTH, MAX_MARGIN);
  localparam int WL = 2 * MAX_MARGIN + 1;
  localparam int SW = WW + MW + 2;

  logic [QW-1:0] q_r;
  logic [CW-1:0] col_r;
  logic [CW-1:0] oc_r;
  logic          row0_r;

  s1_ctl_t        ctl_r;
  logic [CW-1:0]  s1_col_r;
  logic [PIX_BITS-1:0] s1_pix_r;
  logic [WL-1:0]  s1_mask_r;

  logic          acc;
  logic          is_real;
  logic          ignore;
  logic          go;
  logic          started;
  logic          frame_done;
  logic          col_last;
  logic          oc_last;
  logic [QW-1:0] p;
  logic [SW-1:0] reach;
  logic [WL-1:0] mask;

  assign in_ready = en & ~blk & rst_n;
  assign acc      = in_valid & in_ready;
  assign is_real  = q_r < total;
  // A drain word that arrives before the frame is complete is dropped.
  assign ignore   = is_real & (in_op == OP_DRAIN);
  assign go       = acc & ~ignore;
  assign started  = q_r >= delay;
  assign frame_done = started & (q_r >= end_pos);
  assign col_last = (WW'(col_r) + WW'(1)) == w;
  assign oc_last  = (WW'(oc_r) + WW'(1)) == w;
  assign p        = q_r - delay;

  // Window lane k looks at column oc + m - k; keep the lanes inside the row.
  assign reach = SW'(oc_r) + SW'(m);
  always_comb begin
    for (int k = 0; k < WL; k++) begin
      mask[k] = (SW'(k) <= SW'({m, 1'b0})) && (SW'(k) <= reach) &&
                ((SW'(k) + SW'(w)) > reach);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r        <= '0;
      col_r      <= '0;
      oc_r       <= '0;
      row0_r     <= 1'b1;
      ctl_r      <= '0;
    end else if (en) begin
      ctl_r.valid  <= go;
      ctl_r.emit   <= started & (q_r <= end_pos);
      ctl_r.last   <= q_r == end_pos;
      ctl_r.dark   <= is_real & (in_pix < thr);
      ctl_r.row0   <= row0_r;
      ctl_r.bypass <= delay == '0;
      if (go) begin
        if (frame_done) begin
          q_r    <= '0;
          col_r  <= '0;
          oc_r   <= '0;
          row0_r <= 1'b1;
        end else begin
          q_r <= q_r + QW'(1);
          if (col_last) begin
            col_r  <= '0;
            row0_r <= 1'b0;
          end else begin
            col_r <= col_r + CW'(1);
          end
          if (started) begin
            oc_r <= oc_last ? '0 : oc_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_col_r  <= col_r;
      s1_pix_r  <= in_pix;
      s1_mask_r <= mask;
    end
  end

  assign go_o        = go;
  assign col_o       = col_r;
  assign store_we    = go & is_real;
  assign store_waddr = q_r[AW-1:0];
  assign store_raddr = p[AW-1:0];
  assign ctl_o       = ctl_r;
  assign s1_col_o    = s1_col_r;
  assign s1_pix_o    = s1_pix_r;
  assign s1_mask_o   = s1_mask_r;

endmodule

// ===== rtl/swoi_win.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square window obstacle inflation: window stage
// Updates the per-column dark distance, shifts the column flags, masks the
// pixel and holds the output word.
// ----------------------------------------------------------------------------
module swoi_win #(
  parameter int MAX_WIDTH  = swoi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_MARGIN = swoi_pkg::MAX_MARGIN_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  swoi_pkg::s1_ctl_t                     ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]          s1_col,
  input  logic [swoi_pkg::PIX_BITS-1:0]         s1_pix,
  input  logic [2*MAX_MARGIN:0]                 s1_mask,
  input  logic [$clog2(MAX_MARGIN+1)-1:0]       m,
  input  logic                                  go,
  input  logic [$clog2(MAX_WIDTH)-1:0]          s0_col,
  input  logic [$clog2(2*MAX_MARGIN+2)-1:0]     rsd_rdata,
  input  logic [swoi_pkg::PIX_BITS-1:0]         store_rdata,
  output logic                                  rsd_we,
  output logic [$clog2(MAX_WIDTH)-1:0]          rsd_waddr,
  output logic [$clog2(2*MAX_MARGIN+2)-1:0]     rsd_wdata,
  output logic                                  en,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [swoi_pkg::PIX_BITS-1:0]         out_pixel,
  output logic                                  out_last
);
  import swoi_pkg::*;

  localparam int MW   = $clog2(MAX_MARGIN + 1);
  localparam int RDW  = $clog2(2 * MAX_MARGIN + 2);
  localparam int SAT  = 2 * MAX_MARGIN + 1;
  localparam int WL   = 2 * MAX_MARGIN + 1;
  localparam int CMPW = (RDW > MW + 1) ? RDW : MW + 1;

  logic [WL-2:0]        win_r;
  logic                 fwd_v_r;
  logic [RDW-1:0]       fwd_val_r;
  logic                 out_valid_r;
  logic [PIX_BITS-1:0]  out_pixel_r;
  logic                 out_last_r;

  logic [RDW-1:0] rsd_old;
  logic [RDW-1:0] rsd_new;
  logic           flag0;
  logic [WL-1:0]  flags;
  logic           any_dark;
  logic           done;

  assign en   = ~out_valid_r | out_ready;
  assign done = en & ctl.valid;

  // The memory reads old data when the previous word writes the same column
  // in the same cycle, so that value is taken from the forward register.
  assign rsd_old = fwd_v_r ? fwd_val_r : rsd_rdata;

  always_comb begin
    if (ctl.dark) begin
      rsd_new = '0;
    end else if (ctl.row0) begin
      rsd_new = RDW'(SAT);
    end else if (rsd_old < RDW'(SAT)) begin
      rsd_new = rsd_old + RDW'(1);
    end else begin
      rsd_new = rsd_old;
    end
  end

  assign flag0    = CMPW'(rsd_new) <= CMPW'({m, 1'b0});
  assign flags    = {win_r, flag0};
  assign any_dark = |(flags & s1_mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      fwd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (done) begin
        win_r <= flags[WL-2:0];
      end
      if (go) begin
        fwd_v_r <= ctl.valid & (s1_col == s0_col);
      end
      if (en) begin
        out_valid_r <= ctl.valid & ctl.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      fwd_val_r <= rsd_new;
    end
    if (done && ctl.emit) begin
      if (any_dark) begin
        out_pixel_r <= '0;
      end else begin
        out_pixel_r <= ctl.bypass ? s1_pix : store_rdata;
      end
      out_last_r <= ctl.last;
    end
  end

  assign rsd_we    = done;
  assign rsd_waddr = s1_col;
  assign rsd_wdata = rsd_new;
  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule

// ===== bench/swoi_inflation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square window obstacle inflation: stream checker
// Watches the configuration port and both channels, predicts every inflated
// pixel from the accepted input words and compares it with the output words.
// ----------------------------------------------------------------------------
module swoi_inflation_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  swoi_in_if                          in_ch,
  swoi_out_if                         out_ch,
  input  logic                        cfg_we,
  input  logic [swoi_pkg::CFG_IW-1:0] cfg_index,
  input  logic [swoi_pkg::CFG_DW-1:0] cfg_wdata,
  output int unsigned                 errors,
  output int unsigned                 waiting
);
  import swoi_pkg::*;

  localparam int unsigned STORE_DEPTH = (MAX_MARGIN_DEF + 1) * MAX_WIDTH_DEF + MAX_MARGIN_DEF;
  localparam int unsigned WINDOW_LEN  = 2 * MAX_MARGIN_DEF + 1;
  localparam int unsigned ROWS_SAT    = WINDOW_LEN;
  localparam int unsigned PRINT_CAP   = 100;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel;
    logic                last;
  } inflated_t;

  logic [IMG_W_BITS-1:0]  width_cfg;
  logic [IMG_H_BITS-1:0]  height_cfg;
  logic [MARGIN_BITS-1:0] margin_cfg;
  logic [PIX_BITS-1:0]    thresh_cfg;

  logic [PIX_BITS-1:0] delayed_pixels [STORE_DEPTH];
  int unsigned         clear_rows [MAX_WIDTH_DEF];
  bit                  near_dark [WINDOW_LEN];
  int unsigned         in_row;
  int unsigned         in_col;

  inflated_t expected_pixels [$];
  inflated_t want;

  task automatic flag_mismatch(input string what);
    if (errors < PRINT_CAP) $display("%0t ns: mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic clear_state();
    width_cfg  = IMG_W_BITS'(RESET_WIDTH);
    height_cfg = IMG_H_BITS'(RESET_HEIGHT);
    margin_cfg = MARGIN_BITS'(RESET_MARGIN);
    thresh_cfg = PIX_BITS'(RESET_THRESHOLD);
    foreach (delayed_pixels[i]) delayed_pixels[i] = '0;
    foreach (clear_rows[i]) clear_rows[i] = ROWS_SAT;
    foreach (near_dark[i]) near_dark[i] = 1'b0;
    in_row = 0;
    in_col = 0;
    expected_pixels.delete();
  endtask

  // Advances the window state by one accepted word and queues the pixel that
  // leaves the delay line, if any.
  task automatic inflate_word(input op_t op, input logic [PIX_BITS-1:0] pix);
    int unsigned w, h, m, total, lag, q, p, c;
    int          col;
    bit          is_pixel, dark, hit;
    inflated_t   res;
    w = 32'(width_cfg);
    h = 32'(height_cfg);
    m = 32'(margin_cfg);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (m > MAX_MARGIN_DEF) m = MAX_MARGIN_DEF;
    total = w * h;
    lag   = m * w + m;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    q = in_row * w + in_col;
    // A drain word while the frame is still filling is dropped without effect.
    if (q < total) begin
      if (op == OP_DRAIN) return;
      is_pixel = 1'b1;
    end else begin
      is_pixel = 1'b0;
    end
    dark = is_pixel && (pix < thresh_cfg);
    if (dark) clear_rows[in_col] = 0;
    else if (in_row == 0) clear_rows[in_col] = ROWS_SAT;
    else if (clear_rows[in_col] < ROWS_SAT) clear_rows[in_col]++;
    for (int k = WINDOW_LEN - 1; k > 0; k--) near_dark[k] = near_dark[k-1];
    near_dark[0] = (clear_rows[in_col] <= 2 * m);
    if (is_pixel) delayed_pixels[q % STORE_DEPTH] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (q >= lag) begin
      p = q - lag;
      if (p < total) begin
        c   = p % w;
        hit = 1'b0;
        for (int k = 0; k <= 2 * m; k++) begin
          col = int'(c) + int'(m) - k;
          if (col >= 0 && col < int'(w) && near_dark[k]) hit = 1'b1;
        end
        res.pixel = hit ? '0 : delayed_pixels[p % STORE_DEPTH];
        res.last  = (p == total - 1);
        expected_pixels = {expected_pixels, res};
      end
      if (p >= total - 1) begin
        in_row = 0;
        in_col = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH:    width_cfg  = cfg_wdata[IMG_W_BITS-1:0];
          REG_IMAGE_HEIGHT:   height_cfg = cfg_wdata[IMG_H_BITS-1:0];
          REG_MARGIN:         margin_cfg = cfg_wdata[MARGIN_BITS-1:0];
          REG_DARK_THRESHOLD: thresh_cfg = cfg_wdata[PIX_BITS-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) inflate_word(in_ch.op, in_ch.pixel_in);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          flag_mismatch($sformatf("word with nothing pending: pixel_out=%0d last=%0b",
                                  out_ch.pixel_out, out_ch.last));
        end else begin
          want = expected_pixels.pop_front();
          if (out_ch.pixel_out !== want.pixel)
            flag_mismatch($sformatf("pixel_out=%0d, predicted %0d",
                                    out_ch.pixel_out, want.pixel));
          if (out_ch.last !== want.last)
            flag_mismatch($sformatf("last=%0b, predicted %0b", out_ch.last, want.last));
        end
      end
    end
    waiting = expected_pixels.size();
  end

endmodule

// ===== bench/square_window_obstacle_inflation_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square window obstacle inflation: testbench top
// Drives whole frames with their drain tails under several register settings,
// stalls both channels at random and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module square_window_obstacle_inflation_test;
  import swoi_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 10_000_000;
  localparam int unsigned RANDOM_WORDS  = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [3:0]  ALL_REGS      = 4'b1111;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  int unsigned errors;
  int unsigned waiting;
  int unsigned cycles;
  int unsigned words_sent;
  int unsigned hold_left;
  bit          calm;

  logic [IMG_W_BITS-1:0]  cur_w;
  logic [IMG_H_BITS-1:0]  cur_h;
  logic [MARGIN_BITS-1:0] cur_m;
  logic [PIX_BITS-1:0]    cur_thr;

  swoi_in_if  in_if ();
  swoi_out_if out_if ();

  square_window_obstacle_inflation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  swoi_inflation_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .waiting   (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      hold_left    <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Ready is sampled at the falling edge, where it has settled for the cycle.
  task automatic send_word(input op_t op, input logic [PIX_BITS-1:0] pix);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.pixel_in <= pix;
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] mask, input logic [CFG_DW-1:0] w, h, m, thr);
    if (mask[REG_IMAGE_WIDTH]) begin
      set_reg(REG_IMAGE_WIDTH, w);
      cur_w = w[IMG_W_BITS-1:0];
    end
    if (mask[REG_IMAGE_HEIGHT]) begin
      set_reg(REG_IMAGE_HEIGHT, h);
      cur_h = h[IMG_H_BITS-1:0];
    end
    if (mask[REG_MARGIN]) begin
      set_reg(REG_MARGIN, m);
      cur_m = m[MARGIN_BITS-1:0];
    end
    if (mask[REG_DARK_THRESHOLD]) begin
      set_reg(REG_DARK_THRESHOLD, thr);
      cur_thr = thr[PIX_BITS-1:0];
    end
    cfg_we <= 1'b0;
  endtask

  // Dark with the given percentage, sometimes right at the threshold.
  function automatic logic [PIX_BITS-1:0] pick_pixel(input int unsigned density,
                                                      input bit force_dark);
    if (cur_thr != 0 && (force_dark || $urandom_range(0, 99) < density)) begin
      if ($urandom_range(0, 9) == 0) return PIX_BITS'(cur_thr - 1);
      return PIX_BITS'($urandom_range(0, cur_thr - 1));
    end
    if ($urandom_range(0, 9) == 0) return cur_thr;
    return PIX_BITS'($urandom_range(cur_thr, 255));
  endfunction

  // One full frame and its drain tail. With noise, early drain words are
  // mixed in (dropped by the block), some tail words are pixels, and a few
  // drain words may follow the frame end.
  task automatic run_frame(input int unsigned density, input int dark_pos, input bit noise);
    int unsigned w, h, m, total, lag;
    w = 32'(cur_w);
    h = 32'(cur_h);
    m = 32'(cur_m);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (m > MAX_MARGIN_DEF) m = MAX_MARGIN_DEF;
    total = w * h;
    lag   = m * w + m;
    for (int unsigned i = 0; i < total; i++) begin
      if (noise && $urandom_range(0, 19) == 0)
        send_word(OP_DRAIN, PIX_BITS'($urandom_range(0, 255)));
      send_word(OP_PIXEL, pick_pixel(density, int'(i) == dark_pos));
    end
    for (int unsigned i = 0; i < lag; i++) begin
      if (noise && $urandom_range(0, 7) == 0)
        send_word(OP_PIXEL, PIX_BITS'($urandom_range(0, 255)));
      else send_word(OP_DRAIN, PIX_BITS'($urandom_range(0, 255)));
    end
    if (noise && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_word(OP_DRAIN, PIX_BITS'($urandom_range(0, 255)));
    words_sent += total + lag;
    settle();
  endtask

  initial begin
    int unsigned         base;
    logic [CFG_DW-1:0]   w_raw, h_raw, m_raw, t_raw;
    logic [3:0]          mask;
    int unsigned         r;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.op       <= OP_PIXEL;
    in_if.pixel_in <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_IMAGE_WIDTH;
    cfg_wdata      <= '0;
    cur_w   = IMG_W_BITS'(RESET_WIDTH);
    cur_h   = IMG_H_BITS'(RESET_HEIGHT);
    cur_m   = MARGIN_BITS'(RESET_MARGIN);
    cur_thr = PIX_BITS'(RESET_THRESHOLD);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // A single row leaves the reset width, margin and threshold in force.
    configure(4'b0010, 0, 1, 0, 0);
    run_frame(20, -1, 1'b0);
    // One-pixel frames, threshold at both extremes.
    configure(ALL_REGS, 1, 1, 0, 0);
    run_frame(100, -1, 1'b0);
    configure(ALL_REGS, 1, 1, 8, 255);
    run_frame(0, 0, 1'b0);
    // A lone obstacle inside the map, then in the first and last corners.
    configure(ALL_REGS, 5, 4, 1, 100);
    run_frame(0, 7, 1'b0);
    configure(ALL_REGS, 5, 4, 2, 100);
    run_frame(0, 0, 1'b0);
    run_frame(0, 19, 1'b0);
    configure(ALL_REGS, 3, 3, 0, 200);
    run_frame(50, -1, 1'b0);
    // Out-of-range settings: zero width, oversize width and margin.
    configure(ALL_REGS, 0, 3, 15, 128);
    run_frame(30, -1, 1'b0);
    configure(ALL_REGS, 2047, 1, 0, 128);
    run_frame(5, -1, 1'b0);
    configure(ALL_REGS, 7, 2, 8, 255);
    run_frame(0, -1, 1'b0);

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      mask = 4'($urandom_range(1, 15));
      r = $urandom_range(0, 19);
      if (r == 0) w_raw = CFG_DW'($urandom_range(13, 64));
      else if (r == 1) w_raw = 0;
      else w_raw = CFG_DW'($urandom_range(1, 12));
      w_raw[CFG_DW-1:IMG_W_BITS] = 2'($urandom_range(0, 3));
      h_raw = ($urandom_range(0, 19) == 0) ? '0 : CFG_DW'($urandom_range(1, 6));
      m_raw = ($urandom_range(0, 9) == 0) ? CFG_DW'($urandom_range(9, 15))
                                           : CFG_DW'($urandom_range(0, 8));
      m_raw[CFG_DW-1:MARGIN_BITS] = 9'($urandom_range(0, 511));
      t_raw = CFG_DW'($urandom_range(0, 255));
      t_raw[CFG_DW-1:PIX_BITS] = 5'($urandom_range(0, 31));
      configure(mask, w_raw, h_raw, m_raw, t_raw);
      r = $urandom_range(0, 3);
      run_frame($urandom_range(0, 30), (r == 0) ? int'($urandom_range(0, 40)) : -1, 1'b1);
    end
    calm = 1'b0;

    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
